@@ src/awu_pkg.sv @@
`timescale 1ns / 1ps

package awu_pkg;

	// sizes
	localparam int MAX_WEIGHTS = 4096;
	localparam int IDX_W       = 12;
	localparam int CNT_W       = 13;

	// register reset values, binary32 bits
	localparam logic [31:0] BETA1_RST  = 32'h3F666666;
	localparam logic [31:0] BETA2_RST  = 32'h3F7FBE77;
	localparam logic [31:0] EPS_RST    = 32'h358637BD;
	localparam logic [31:0] LR_RST     = 32'h3A83126F;
	localparam logic [CNT_W-1:0] WCOUNT_RST = CNT_W'(MAX_WEIGHTS);

	// float constants
	localparam logic [31:0] FP_ONE      = 32'h3F800000;
	localparam logic [31:0] FP_DEF_NAN  = 32'hFFC00000;
	localparam logic [31:0] FP_SQRT_NAN = 32'h7FC00000;
	localparam logic [31:0] FP_QUIET    = 32'h00400000;

	// register indexes on the config port
	localparam logic [2:0] REG_BETA1  = 3'd0;
	localparam logic [2:0] REG_BETA2  = 3'd1;
	localparam logic [2:0] REG_EPS    = 3'd2;
	localparam logic [2:0] REG_LR     = 3'd3;
	localparam logic [2:0] REG_WCOUNT = 3'd4;

	typedef enum logic [2:0] {
		FOP_ADD,
		FOP_SUB,
		FOP_MUL,
		FOP_DIV,
		FOP_SQRT
	} fpu_op_t;

	typedef struct packed {
		logic        start;
		fpu_op_t     op;
		logic [31:0] a;
		logic [31:0] b;
	} fpu_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] result;
	} fpu_rsp_t;

	typedef enum logic [3:0] {
		F_IDLE,
		F_PRENORM,
		F_EXEC,
		F_ADD,
		F_ITER,
		F_POST,
		F_NORM,
		F_RSHIFT,
		F_ROUND,
		F_DONE
	} fpu_state_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_ISSUE,
		ST_WAIT,
		ST_WRITE,
		ST_DONE
	} main_state_t;

	typedef enum logic [4:0] {
		S_C1,
		S_T1M,
		S_T2M,
		S_MV,
		S_C2,
		S_GG,
		S_T1V,
		S_T2V,
		S_VV,
		S_C1P,
		S_MHAT,
		S_C2P,
		S_VHAT,
		S_SQRT,
		S_DEN,
		S_Q,
		S_STEP,
		S_NW,
		S_BP1,
		S_BP2
	} step_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		logic [31:0]      m;
		logic [31:0]      v;
	} mem_wr_t;

endpackage

@@ src/adam_weight_update_top.sv @@
`timescale 1ns / 1ps
// time from item to result is set by the shared float unit and is longer when the item
// ends an optimizer step, longer with subnormal operands or cancellation, shorter
// with special operands; an index at or above the count skips the float unit
// throughput: one item at a time, the next item is taken once the result is registered
// reset: moment memories cleared by a pass over every address after reset, no item taken then
module adam_weight_update_top import awu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// slave side, tdata: weight_in[31:0], gradient[63:32], weight_index[75:64], zero pad
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,
	// master side, tdata: weight_out[31:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,
	// tuser: index_error[0]
	output logic        m_tuser,
	// config port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	main_state_t      state_q, state_d;
	step_t            step_q;
	logic [31:0]      beta1_q, beta2_q, eps_q, lr_q, bp1_q, bp2_q;
	logic [CNT_W-1:0] wcount_q;
	logic [IDX_W-1:0] upd_q, idx_q, clr_addr_q;
	logic [31:0]      w_q, g_q, c_q, t1_q, t2_q, gg_q, mval_q, vval_q, mhat_q;
	logic             err_q;
	logic             m_tvalid_q, m_tuser_q;
	logic [31:0]      m_tdata_q;
	logic [CNT_W-1:0] limit, upd_next;
	logic             wrap, idx_bad, cfg_wr, accept, out_free, op_done;
	logic [31:0]      rd_m, rd_v;
	fpu_req_t         fpu_req;
	fpu_rsp_t         fpu_rsp;
	mem_wr_t          mem_wr;

	// step count and index check
	assign limit    = (wcount_q > CNT_W'(MAX_WEIGHTS)) ? CNT_W'(MAX_WEIGHTS) : wcount_q;
	assign upd_next = {1'b0, upd_q} + CNT_W'(1);
	assign wrap     = (upd_next >= limit);
	assign idx_bad  = ({1'b0, s_tdata[75:64]} >= limit);
	assign cfg_wr   = psel && penable && pwrite;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign op_done  = fpu_rsp.done;

	// config registers and running powers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta1_q  <= BETA1_RST;
			beta2_q  <= BETA2_RST;
			eps_q    <= EPS_RST;
			lr_q     <= LR_RST;
			wcount_q <= WCOUNT_RST;
			bp1_q    <= BETA1_RST;
			bp2_q    <= BETA2_RST;
		end else begin
			if (cfg_wr) begin
				unique case (paddr[4:2])
					REG_BETA1: begin
						beta1_q <= pwdata;
						bp1_q   <= pwdata;
					end
					REG_BETA2: begin
						beta2_q <= pwdata;
						bp2_q   <= pwdata;
					end
					REG_EPS:    eps_q    <= pwdata;
					REG_LR:     lr_q     <= pwdata;
					REG_WCOUNT: wcount_q <= pwdata[CNT_W-1:0];
					default: begin
					end
				endcase
			end
			if ((state_q == ST_WAIT) && op_done) begin
				if (step_q == S_BP1) bp1_q <= fpu_rsp.result;
				if (step_q == S_BP2) bp2_q <= fpu_rsp.result;
			end
		end
	end

	// register read back
	always_comb begin
		unique case (paddr[4:2])
			REG_BETA1:  prdata = beta1_q;
			REG_BETA2:  prdata = beta2_q;
			REG_EPS:    prdata = eps_q;
			REG_LR:     prdata = lr_q;
			REG_WCOUNT: prdata = {19'd0, wcount_q};
			default:    prdata = 32'd0;
		endcase
	end
	assign pready = 1'b1;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and control outputs
	always_comb begin
		state_d       = state_q;
		s_tready      = 1'b0;
		mem_wr.en     = 1'b0;
		mem_wr.addr   = idx_q;
		mem_wr.m      = mval_q;
		mem_wr.v      = vval_q;
		unique case (state_q)
			ST_CLEAR: begin
				mem_wr.en   = 1'b1;
				mem_wr.addr = clr_addr_q;
				mem_wr.m    = 32'd0;
				mem_wr.v    = 32'd0;
				if (clr_addr_q == {IDX_W{1'b1}}) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) state_d = idx_bad ? ST_DONE : ST_READ;
			end
			ST_READ:  state_d = ST_ISSUE;
			ST_ISSUE: state_d = ST_WAIT;
			ST_WAIT: begin
				if (op_done) begin
					if (step_q == S_NW) state_d = wrap ? ST_ISSUE : ST_WRITE;
					else if (step_q == S_BP2) state_d = ST_WRITE;
					else state_d = ST_ISSUE;
				end
			end
			ST_WRITE: begin
				mem_wr.en = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// operation of each step
	always_comb begin
		fpu_req.start = (state_q == ST_ISSUE);
		fpu_req.op    = FOP_ADD;
		fpu_req.a     = 32'd0;
		fpu_req.b     = 32'd0;
		unique case (step_q)
			S_C1:   begin fpu_req.op = FOP_SUB;  fpu_req.a = FP_ONE;  fpu_req.b = beta1_q; end
			S_T1M:  begin fpu_req.op = FOP_MUL;  fpu_req.a = beta1_q; fpu_req.b = rd_m;    end
			S_T2M:  begin fpu_req.op = FOP_MUL;  fpu_req.a = c_q;     fpu_req.b = g_q;     end
			S_MV:   begin fpu_req.op = FOP_ADD;  fpu_req.a = t1_q;    fpu_req.b = t2_q;    end
			S_C2:   begin fpu_req.op = FOP_SUB;  fpu_req.a = FP_ONE;  fpu_req.b = beta2_q; end
			S_GG:   begin fpu_req.op = FOP_MUL;  fpu_req.a = g_q;     fpu_req.b = g_q;     end
			S_T1V:  begin fpu_req.op = FOP_MUL;  fpu_req.a = beta2_q; fpu_req.b = rd_v;    end
			S_T2V:  begin fpu_req.op = FOP_MUL;  fpu_req.a = c_q;     fpu_req.b = gg_q;    end
			S_VV:   begin fpu_req.op = FOP_ADD;  fpu_req.a = t1_q;    fpu_req.b = t2_q;    end
			S_C1P:  begin fpu_req.op = FOP_SUB;  fpu_req.a = FP_ONE;  fpu_req.b = bp1_q;   end
			S_MHAT: begin fpu_req.op = FOP_DIV;  fpu_req.a = mval_q;  fpu_req.b = c_q;     end
			S_C2P:  begin fpu_req.op = FOP_SUB;  fpu_req.a = FP_ONE;  fpu_req.b = bp2_q;   end
			S_VHAT: begin fpu_req.op = FOP_DIV;  fpu_req.a = vval_q;  fpu_req.b = c_q;     end
			S_SQRT: begin fpu_req.op = FOP_SQRT; fpu_req.a = t1_q;    fpu_req.b = 32'd0;   end
			S_DEN:  begin fpu_req.op = FOP_ADD;  fpu_req.a = t1_q;    fpu_req.b = eps_q;   end
			S_Q:    begin fpu_req.op = FOP_DIV;  fpu_req.a = mhat_q;  fpu_req.b = t1_q;    end
			S_STEP: begin fpu_req.op = FOP_MUL;  fpu_req.a = lr_q;    fpu_req.b = t1_q;    end
			S_NW:   begin fpu_req.op = FOP_SUB;  fpu_req.a = w_q;     fpu_req.b = t1_q;    end
			S_BP1:  begin fpu_req.op = FOP_MUL;  fpu_req.a = bp1_q;   fpu_req.b = beta1_q; end
			S_BP2:  begin fpu_req.op = FOP_MUL;  fpu_req.a = bp2_q;   fpu_req.b = beta2_q; end
			default: begin
			end
		endcase
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			upd_q      <= '0;
			step_q     <= S_C1;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) clr_addr_q <= clr_addr_q + IDX_W'(1);
			if (accept) step_q <= S_C1;
			else if ((state_q == ST_WAIT) && op_done) step_q <= step_t'(step_q + 5'd1);
			if (state_q == ST_WRITE) upd_q <= wrap ? '0 : upd_next[IDX_W-1:0];
			if ((state_q == ST_DONE) && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// item and intermediate values
	always_ff @(posedge clk) begin
		if (accept) begin
			w_q   <= s_tdata[31:0];
			g_q   <= s_tdata[63:32];
			idx_q <= s_tdata[75:64];
			err_q <= idx_bad;
		end
		if ((state_q == ST_WAIT) && op_done) begin
			unique case (step_q)
				S_C1, S_C2, S_C1P, S_C2P:                      c_q    <= fpu_rsp.result;
				S_T1M, S_T1V, S_VHAT, S_SQRT, S_DEN, S_Q, S_STEP: t1_q   <= fpu_rsp.result;
				S_T2M, S_T2V, S_NW:                            t2_q   <= fpu_rsp.result;
				S_MV:                                          mval_q <= fpu_rsp.result;
				S_GG:                                          gg_q   <= fpu_rsp.result;
				S_VV:                                          vval_q <= fpu_rsp.result;
				S_MHAT:                                        mhat_q <= fpu_rsp.result;
				default: begin
				end
			endcase
		end
		// output register
		if ((state_q == ST_DONE) && out_free) begin
			m_tdata_q <= err_q ? w_q : t2_q;
			m_tuser_q <= err_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	awu_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fpu_req),
		.rsp    (fpu_rsp)
	);

	awu_moment_store u_store (
		.clk   (clk),
		.wr    (mem_wr),
		.raddr (idx_q),
		.rd_m  (rd_m),
		.rd_v  (rd_v)
	);

endmodule

@@ src/awu_moment_store.sv @@
`timescale 1ns / 1ps

module awu_moment_store import awu_pkg::*; (
	input  logic             clk,
	input  mem_wr_t          wr,
	input  logic [IDX_W-1:0] raddr,
	output logic [31:0]      rd_m,
	output logic [31:0]      rd_v
);

	logic [31:0] m_mem [MAX_WEIGHTS];
	logic [31:0] v_mem [MAX_WEIGHTS];
	logic [31:0] rd_m_q;
	logic [31:0] rd_v_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			m_mem[wr.addr] <= wr.m;
			v_mem[wr.addr] <= wr.v;
		end
		rd_m_q <= m_mem[raddr];
		rd_v_q <= v_mem[raddr];
	end

	assign rd_m = rd_m_q;
	assign rd_v = rd_v_q;

endmodule

@@ src/awu_fpu.sv @@
`timescale 1ns / 1ps

module awu_fpu import awu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  fpu_req_t req,
	output fpu_rsp_t rsp
);

	fpu_state_t         state_q, state_d;
	fpu_op_t            op_q;
	logic               sa_q, sb_q, sr_q, den_q;
	logic signed [9:0]  ea_q, eb_q, er_q;
	logic [23:0]        ma_q, mb_q;
	logic [26:0]        al_q, mant_q;
	logic [25:0]        drem_q;
	logic [27:0]        quo_q, srem_q;
	logic [24:0]        root_q;
	logic [49:0]        rad_q;
	logic [4:0]         cnt_q;
	logic [31:0]        res_q;

	// nan, infinity and zero operands
	function automatic logic [32:0] special_case(fpu_op_t op, logic [31:0] a, logic [31:0] b);
		logic an, bn, ai, bi, az, bz, sbe, sx;
		logic [32:0] r;
		an  = (&a[30:23]) && (|a[22:0]);
		bn  = (&b[30:23]) && (|b[22:0]);
		ai  = (&a[30:23]) && !(|a[22:0]);
		bi  = (&b[30:23]) && !(|b[22:0]);
		az  = (a[30:0] == 31'd0);
		bz  = (b[30:0] == 31'd0);
		sbe = b[31] ^ (op == FOP_SUB);
		sx  = a[31] ^ b[31];
		r   = 33'd0;
		unique case (op)
			FOP_ADD, FOP_SUB: begin
				if (an)            r = {1'b1, a | FP_QUIET};
				else if (bn)       r = {1'b1, b | FP_QUIET};
				else if (ai && bi) r = {1'b1, (a[31] != sbe) ? FP_DEF_NAN : a};
				else if (ai)       r = {1'b1, a};
				else if (bi)       r = {1'b1, sbe, b[30:0]};
				else if (az && bz) r = {1'b1, a[31] & sbe, 31'd0};
				else if (az)       r = {1'b1, sbe, b[30:0]};
				else if (bz)       r = {1'b1, a};
			end
			FOP_MUL: begin
				if (an)                          r = {1'b1, a | FP_QUIET};
				else if (bn)                     r = {1'b1, b | FP_QUIET};
				else if ((ai && bz) || (az && bi)) r = {1'b1, FP_DEF_NAN};
				else if (ai || bi)               r = {1'b1, sx, 8'hFF, 23'd0};
				else if (az || bz)               r = {1'b1, sx, 31'd0};
			end
			FOP_DIV: begin
				if (an)                          r = {1'b1, a | FP_QUIET};
				else if (bn)                     r = {1'b1, b | FP_QUIET};
				else if ((ai && bi) || (az && bz)) r = {1'b1, FP_DEF_NAN};
				else if (ai || bz)               r = {1'b1, sx, 8'hFF, 23'd0};
				else if (bi || az)               r = {1'b1, sx, 31'd0};
			end
			FOP_SQRT: begin
				if (an)         r = {1'b1, a | FP_QUIET};
				else if (az)    r = {1'b1, a};
				else if (a[31]) r = {1'b1, FP_SQRT_NAN};
				else if (ai)    r = {1'b1, a};
			end
			default: r = 33'd0;
		endcase
		return r;
	endfunction

	logic [32:0]       spec;
	logic              swap;
	logic signed [9:0] e_big, e_small, d;
	logic [23:0]       m_big, m_small;
	logic              s_big;
	logic [26:0]       small27, sh27, lostb, al_d;
	logic [27:0]       sum28;
	logic [47:0]       prod;
	logic              d_ok;
	logic [25:0]       d_diff;
	logic [29:0]       s_sh, s_trial, s_diff;
	logic              s_ok;
	logic signed [9:0] sh10;
	logic [26:0]       rs_mant, rs_lost;
	logic              g_bit, st_bit, up;
	logic [24:0]       rsum;
	logic [7:0]        rbase;
	logic [30:0]       rmag;
	logic [24:0]       sq_m;
	logic signed [9:0] sq_e;

	// datapath helpers
	always_comb begin
		spec    = special_case(req.op, req.a, req.b);
		swap    = (eb_q > ea_q) || ((eb_q == ea_q) && (mb_q > ma_q));
		e_big   = swap ? eb_q : ea_q;
		e_small = swap ? ea_q : eb_q;
		m_big   = swap ? mb_q : ma_q;
		m_small = swap ? ma_q : mb_q;
		s_big   = swap ? sb_q : sa_q;
		d       = e_big - e_small;
		small27 = {m_small, 3'b000};
		sh27    = small27 >> d[4:0];
		lostb   = small27 << (5'd27 - d[4:0]);
		if (d >= 10'sd27) al_d = 27'd1;
		else al_d = sh27 | {26'd0, |lostb};
		sum28 = (sa_q ^ sb_q) ? ({1'b0, ma_q, 3'b000} - {1'b0, al_q})
			: ({1'b0, ma_q, 3'b000} + {1'b0, al_q});
		prod   = ma_q * mb_q;
		d_ok   = drem_q >= {2'b00, mb_q};
		d_diff = drem_q - {2'b00, mb_q};
		s_sh    = {srem_q, rad_q[49:48]};
		s_trial = {3'b000, root_q, 2'b01};
		s_ok    = s_sh >= s_trial;
		s_diff  = s_sh - s_trial;
		// sqrt exponent made even
		if (!ea_q[0]) begin
			sq_m = {ma_q, 1'b0};
			sq_e = ((ea_q - 10'sd128) >>> 1) + 10'sd127;
		end else begin
			sq_m = {1'b0, ma_q};
			sq_e = ((ea_q - 10'sd127) >>> 1) + 10'sd127;
		end
		// shift into the subnormal range
		sh10    = 10'sd1 - er_q;
		rs_lost = mant_q << (5'd27 - sh10[4:0]);
		if (sh10 >= 10'sd27) rs_mant = {26'd0, |mant_q};
		else rs_mant = (mant_q >> sh10[4:0]) | {26'd0, |rs_lost};
		// round to nearest even
		g_bit  = mant_q[2];
		st_bit = |mant_q[1:0];
		up     = g_bit && (st_bit || mant_q[3]);
		rsum   = {1'b0, mant_q[26:3]} + {24'd0, up};
		rbase  = den_q ? 8'd0 : 8'(er_q - 10'sd1);
		rmag   = {rbase, 23'd0} + {6'd0, rsum};
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (req.start) state_d = spec[32] ? F_DONE : F_PRENORM;
			end
			F_PRENORM: begin
				if (ma_q[23] && mb_q[23]) state_d = F_EXEC;
			end
			F_EXEC: begin
				unique case (op_q)
					FOP_MUL:          state_d = F_RSHIFT;
					FOP_ADD, FOP_SUB: state_d = F_ADD;
					default:          state_d = F_ITER;
				endcase
			end
			F_ADD: begin
				if (sum28 == 28'd0) state_d = F_DONE;
				else if (sum28[27]) state_d = F_RSHIFT;
				else state_d = F_NORM;
			end
			F_ITER: begin
				if (cnt_q == 5'd1) state_d = F_POST;
			end
			F_POST:   state_d = F_RSHIFT;
			F_NORM: begin
				if (mant_q[26]) state_d = F_RSHIFT;
			end
			F_RSHIFT: state_d = F_ROUND;
			F_ROUND:  state_d = F_DONE;
			F_DONE:   state_d = F_IDLE;
			default:  state_d = F_IDLE;
		endcase
	end

	// operand and result registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				if (req.start) begin
					op_q  <= req.op;
					res_q <= spec[31:0];
					sa_q  <= req.a[31];
					sb_q  <= req.b[31] ^ (req.op == FOP_SUB);
					ea_q  <= (req.a[30:23] == 8'd0) ? 10'sd1 : $signed({2'b00, req.a[30:23]});
					ma_q  <= {(req.a[30:23] != 8'd0), req.a[22:0]};
					if (req.op == FOP_SQRT) begin
						eb_q <= 10'sd0;
						mb_q <= 24'h800000;
					end else begin
						eb_q <= (req.b[30:23] == 8'd0) ? 10'sd1
							: $signed({2'b00, req.b[30:23]});
						mb_q <= {(req.b[30:23] != 8'd0), req.b[22:0]};
					end
				end
			end
			F_PRENORM: begin
				// subnormal operands get a leading one
				if (!ma_q[23]) begin
					if (ma_q[23:16] == 8'd0) begin
						ma_q <= ma_q << 8;
						ea_q <= ea_q - 10'sd8;
					end else begin
						ma_q <= ma_q << 1;
						ea_q <= ea_q - 10'sd1;
					end
				end
				if (!mb_q[23]) begin
					if (mb_q[23:16] == 8'd0) begin
						mb_q <= mb_q << 8;
						eb_q <= eb_q - 10'sd8;
					end else begin
						mb_q <= mb_q << 1;
						eb_q <= eb_q - 10'sd1;
					end
				end
			end
			F_EXEC: begin
				unique case (op_q)
					FOP_MUL: begin
						sr_q <= sa_q ^ sb_q;
						if (prod[47]) begin
							mant_q <= {prod[47:22], |prod[21:0]};
							er_q   <= ea_q + eb_q - 10'sd126;
						end else begin
							mant_q <= {prod[46:21], |prod[20:0]};
							er_q   <= ea_q + eb_q - 10'sd127;
						end
					end
					FOP_ADD, FOP_SUB: begin
						// larger magnitude goes to a, smaller one aligned
						ma_q <= m_big;
						ea_q <= e_big;
						sr_q <= s_big;
						al_q <= al_d;
					end
					FOP_DIV: begin
						sr_q   <= sa_q ^ sb_q;
						er_q   <= ea_q - eb_q + 10'sd127;
						drem_q <= {2'b00, ma_q};
						quo_q  <= 28'd0;
						cnt_q  <= 5'd28;
					end
					default: begin
						sr_q   <= 1'b0;
						er_q   <= sq_e;
						rad_q  <= {sq_m, 25'd0};
						srem_q <= 28'd0;
						root_q <= 25'd0;
						cnt_q  <= 5'd25;
					end
				endcase
			end
			F_ADD: begin
				er_q <= ea_q;
				if (sum28 == 28'd0) begin
					res_q <= 32'd0;
				end else if (sum28[27]) begin
					mant_q <= {sum28[27:2], sum28[1] | sum28[0]};
					er_q   <= ea_q + 10'sd1;
				end else begin
					mant_q <= sum28[26:0];
				end
			end
			F_ITER: begin
				cnt_q <= cnt_q - 5'd1;
				if (op_q == FOP_DIV) begin
					// restoring division, one quotient bit
					quo_q  <= {quo_q[26:0], d_ok};
					drem_q <= d_ok ? {d_diff[24:0], 1'b0} : {drem_q[24:0], 1'b0};
				end else begin
					// digit by digit square root, one root bit
					rad_q  <= {rad_q[47:0], 2'b00};
					root_q <= {root_q[23:0], s_ok};
					srem_q <= s_ok ? s_diff[27:0] : s_sh[27:0];
				end
			end
			F_POST: begin
				if (op_q == FOP_DIV) begin
					if (quo_q[27]) begin
						mant_q <= {quo_q[27:2], quo_q[1] | quo_q[0] | (|drem_q)};
					end else begin
						mant_q <= {quo_q[26:1], quo_q[0] | (|drem_q)};
						er_q   <= er_q - 10'sd1;
					end
				end else begin
					mant_q <= {root_q, 1'b0, |srem_q};
				end
			end
			F_NORM: begin
				// cancellation, shift the leading one back up
				if (!mant_q[26]) begin
					if (mant_q[26:19] == 8'd0) begin
						mant_q <= mant_q << 8;
						er_q   <= er_q - 10'sd8;
					end else begin
						mant_q <= mant_q << 1;
						er_q   <= er_q - 10'sd1;
					end
				end
			end
			F_RSHIFT: begin
				den_q <= (er_q < 10'sd1);
				if (er_q < 10'sd1) mant_q <= rs_mant;
			end
			F_ROUND: begin
				if (!den_q && (er_q >= 10'sd255)) res_q <= {sr_q, 8'hFF, 23'd0};
				else res_q <= {sr_q, rmag};
			end
			F_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign rsp.done   = (state_q == F_DONE);
	assign rsp.result = res_q;

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

import awu_pkg::*;

// adam weight update scoreboard: binary32 predictor with its own moment stores
class adam_scoreboard;

	typedef struct {
		logic [31:0] weight;
		logic        bad_index;
	} adam_result_t;

	logic [31:0] beta1, beta2, eps_term, lr;
	logic [12:0] wcount;
	logic [31:0] first_mom [MAX_WEIGHTS];
	logic [31:0] second_mom [MAX_WEIGHTS];
	logic [31:0] beta1_pow, beta2_pow;
	int unsigned updates_done;
	adam_result_t pending_results [$];
	int mismatches;
	int items_seen, bad_indexes, steps_ended;

	function void clear();
		beta1 = BETA1_RST;
		beta2 = BETA2_RST;
		eps_term = EPS_RST;
		lr = LR_RST;
		wcount = WCOUNT_RST;
		foreach (first_mom[i]) begin
			first_mom[i] = '0;
			second_mom[i] = '0;
		end
		beta1_pow = BETA1_RST;
		beta2_pow = BETA2_RST;
		updates_done = 0;
		pending_results.delete();
		mismatches = 0;
		items_seen = 0;
		bad_indexes = 0;
		steps_ended = 0;
	endfunction

	function void write_reg(logic [2:0] idx, logic [31:0] val);
		case (idx)
			REG_BETA1: begin
				beta1 = val;
				beta1_pow = val;
			end
			REG_BETA2: begin
				beta2 = val;
				beta2_pow = val;
			end
			REG_EPS: eps_term = val;
			REG_LR: lr = val;
			REG_WCOUNT: wcount = val[12:0];
			default: ;
		endcase
	endfunction

	function bit is_nan(logic [31:0] x);
		return x[30:23] == 8'hFF && x[22:0] != 0;
	endfunction

	function bit is_inf(logic [31:0] x);
		return x[30:0] == 31'h7F800000;
	endfunction

	function bit is_zero(logic [31:0] x);
		return x[30:0] == 0;
	endfunction

	// exact binary32 to double
	function real to_real(logic [31:0] b);
		real r;
		if (b[30:23] == 0) begin
			if (b[22:0] == 0)
				return $bitstoreal({b[31], 63'b0});
			r = real'(b[22:0]) * (2.0 ** -149);
			return b[31] ? -r : r;
		end
		if (b[30:23] == 8'hFF)
			return $bitstoreal({b[31], 11'h7FF, 52'b0});
		return $bitstoreal({b[31], 11'(b[30:23] + 896), b[22:0], 29'b0});
	endfunction

	// double to binary32, round to nearest even, subnormals kept
	function logic [31:0] from_real(real r);
		logic [63:0] d;
		logic [63:0] m, q, rem, half;
		int e, sh;
		d = $realtobits(r);
		if (d[62:52] == 11'h7FF)
			return {d[63], 8'hFF, (d[51:0] != 0) ? 23'h400000 : 23'h0};
		if (d[62:52] == 0)
			return {d[63], 31'b0};
		e = int'(d[62:52]) - 1023;
		if (e > 127)
			return {d[63], 31'h7F800000};
		m = {11'b0, 1'b1, d[51:0]};
		sh = (e >= -126) ? 29 : 29 + (-126 - e);
		if (sh > 60)
			return {d[63], 31'b0};
		q = m >> sh;
		rem = m & ((64'd1 << sh) - 1);
		half = 64'd1 << (sh - 1);
		if (rem > half || (rem == half && q[0]))
			q = q + 1;
		if (e >= -126) begin
			if (q == 64'h1000000) begin
				q = q >> 1;
				e = e + 1;
			end
			if (e > 127)
				return {d[63], 31'h7F800000};
			return {d[63], 8'(e + 127), q[22:0]};
		end
		return {d[63], q[30:0]};
	endfunction

	// one binary32 operation with x86-style nan rules
	function logic [31:0] fop(fpu_op_t op, logic [31:0] a, logic [31:0] b);
		real ra, rb;
		if (op == FOP_SQRT) begin
			if (is_nan(a))
				return a | FP_QUIET;
			if (is_zero(a))
				return a;
			if (a[31])
				return FP_SQRT_NAN;
			if (is_inf(a))
				return a;
			return from_real($sqrt(to_real(a)));
		end
		if (is_nan(a))
			return a | FP_QUIET;
		if (is_nan(b))
			return b | FP_QUIET;
		ra = to_real(a);
		rb = to_real(b);
		case (op)
			FOP_ADD: begin
				if (is_inf(a) && is_inf(b) && a[31] != b[31])
					return FP_DEF_NAN;
				return from_real(ra + rb);
			end
			FOP_SUB: begin
				if (is_inf(a) && is_inf(b) && a[31] == b[31])
					return FP_DEF_NAN;
				return from_real(ra - rb);
			end
			FOP_MUL: begin
				if ((is_zero(a) && is_inf(b)) || (is_inf(a) && is_zero(b)))
					return FP_DEF_NAN;
				return from_real(ra * rb);
			end
			default: begin
				if ((is_zero(a) && is_zero(b)) || (is_inf(a) && is_inf(b)))
					return FP_DEF_NAN;
				if (is_zero(b))
					return {a[31] ^ b[31], 31'h7F800000};
				return from_real(ra / rb);
			end
		endcase
	endfunction

	// work out the updated weight for one accepted item
	function void note_item(logic [31:0] w, logic [31:0] g, logic [11:0] idx);
		int unsigned lim;
		logic [31:0] c1, c2, t1, t2, mval, vval, gg, mhat, vhat, den, q, stp;
		adam_result_t r;
		items_seen++;
		lim = (wcount > MAX_WEIGHTS) ? MAX_WEIGHTS : wcount;
		if (idx >= lim) begin
			bad_indexes++;
			r.weight = w;
			r.bad_index = 1'b1;
			pending_results.push_back(r);
			return;
		end
		c1 = fop(FOP_SUB, FP_ONE, beta1);
		t1 = fop(FOP_MUL, beta1, first_mom[idx]);
		t2 = fop(FOP_MUL, c1, g);
		mval = fop(FOP_ADD, t1, t2);
		c2 = fop(FOP_SUB, FP_ONE, beta2);
		gg = fop(FOP_MUL, g, g);
		t1 = fop(FOP_MUL, beta2, second_mom[idx]);
		t2 = fop(FOP_MUL, c2, gg);
		vval = fop(FOP_ADD, t1, t2);
		c1 = fop(FOP_SUB, FP_ONE, beta1_pow);
		mhat = fop(FOP_DIV, mval, c1);
		c2 = fop(FOP_SUB, FP_ONE, beta2_pow);
		vhat = fop(FOP_DIV, vval, c2);
		den = fop(FOP_SQRT, vhat, '0);
		den = fop(FOP_ADD, den, eps_term);
		q = fop(FOP_DIV, mhat, den);
		stp = fop(FOP_MUL, lr, q);
		r.weight = fop(FOP_SUB, w, stp);
		r.bad_index = 1'b0;
		first_mom[idx] = mval;
		second_mom[idx] = vval;
		updates_done++;
		if (updates_done >= lim) begin
			updates_done = 0;
			steps_ended++;
			beta1_pow = fop(FOP_MUL, beta1_pow, beta1);
			beta2_pow = fop(FOP_MUL, beta2_pow, beta2);
		end
		pending_results.push_back(r);
	endfunction

	function void report_mismatch(string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endfunction

	function void check_result(logic [31:0] w, logic bad);
		adam_result_t r;
		if (pending_results.size() == 0) begin
			report_mismatch($sformatf("unexpected item %h err %b", w, bad));
			return;
		end
		r = pending_results.pop_front();
		if (w !== r.weight)
			report_mismatch($sformatf("weight_out %h, expected %h", w, r.weight));
		if (bad !== r.bad_index)
			report_mismatch($sformatf("index_error %b, expected %b", bad, r.bad_index));
	endfunction
endclass

module testbench;
	import awu_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// weight_in, gradient, weight_index, zero pad
	logic [79:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	// weight_out
	logic [31:0] m_tdata;
	// index_error
	logic        m_tuser;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	adam_scoreboard adam_sb;
	bit quiet_phase;
	int stall_left;

	adam_weight_update_top dut (.*);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit
	initial begin
		#25_000_000;
		$display("timeout");
		$display("CHECK FAILED");
		$finish;
	end

	// input side monitor feeds the predictor, output side monitor checks the results
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			adam_sb.note_item(s_tdata[31:0], s_tdata[63:32], s_tdata[75:64]);
		if (arst_n && m_tvalid && m_tready)
			adam_sb.check_result(m_tdata, m_tuser);
	end

	// receiver with random stalls outside quiet phases
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (m_tvalid && m_tready) begin
			if (quiet_phase) begin
				m_tready <= 1'b1;
			end else begin
				stall_left <= $urandom_range(0, 17);
				m_tready <= 1'b0;
			end
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		adam_sb.write_reg(idx, val);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_item(logic [31:0] w, logic [31:0] g, logic [11:0] idx);
		int gap;
		gap = quiet_phase ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, idx, g, w};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (adam_sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_float();
		int k;
		k = $urandom_range(0, 99);
		if (k < 70)
			return {1'($urandom), 8'($urandom_range(110, 135)), 23'($urandom)};
		if (k < 88)
			return $urandom;
		case ($urandom_range(0, 6))
			0: return 32'h00000000;
			1: return 32'h80000000;
			2: return {1'($urandom), 8'h00, 23'($urandom)};
			3: return {1'($urandom), 31'h7F800000};
			4: return {1'($urandom), 8'hFF, 23'($urandom) | 23'h1};
			5: return 32'h7F7FFFFF;
			default: return 32'hFFFFFFFF;
		endcase
	endfunction

	function automatic logic [31:0] rand_beta();
		int k;
		k = $urandom_range(0, 19);
		if (k == 0)
			return 32'h00000000;
		if (k == 1)
			return 32'hFFFFFFFF;
		if (k == 2)
			return FP_ONE;
		return {9'd126, 23'($urandom)};
	endfunction

	// main sequence
	initial begin
		int lim, n;
		logic [12:0] wc;
		logic [11:0] idx;
		adam_sb = new();
		adam_sb.clear();
		quiet_phase = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: default registers, field extremes and special values
		send_item(32'h0, 32'h0, 12'd0);
		send_item(32'hFFFFFFFF, 32'hFFFFFFFF, 12'd4095);
		send_item(32'h3F800000, 32'h7F7FFFFF, 12'd1);
		send_item(32'hBF800000, 32'hFF800000, 12'd2);
		send_item(32'h7F800000, 32'h7FA00000, 12'd3);
		send_item(32'h7FA00001, 32'h3DCCCCCD, 12'd4);
		send_item(32'h80000000, 32'h80000000, 12'd5);
		send_item(32'h00000001, 32'h007FFFFF, 12'd6);
		send_item(32'h3F800000, 32'h3DCCCCCD, 12'd0);
		send_item(32'h12345678, 32'hABCDEF01, 12'haaa);
		send_item(32'hEDCBA987, 32'h5432FEDC, 12'h555);
		drain();
		// count lowered below the updates already done
		reg_write(REG_WCOUNT, 13'd2);
		send_item(32'h3F000000, 32'h3F000000, 12'd1);
		send_item(32'h3F000000, 32'h3F000000, 12'd2);
		send_item(32'h3F000000, 32'h3F000000, 12'd4095);
		send_item(32'h3F000000, 32'hBF000000, 12'd0);
		send_item(32'h3F000000, 32'hBF000000, 12'd1);
		drain();
		// zero count flags every index, oversized count saturates
		reg_write(REG_WCOUNT, 13'd0);
		send_item(32'h40490FDB, 32'h3F800000, 12'd0);
		send_item(32'h40490FDB, 32'h3F800000, 12'd7);
		drain();
		reg_write(REG_WCOUNT, 13'h1FFF);
		reg_write(REG_BETA1, 32'h0);
		reg_write(REG_BETA2, FP_ONE);
		reg_write(REG_EPS, 32'hFFFFFFFF);
		reg_write(REG_LR, 32'h0);
		send_item(32'h3F800000, 32'h3F800000, 12'd4095);
		send_item(32'h3F800000, 32'h40000000, 12'd9);
		drain();
		reg_write(REG_BETA1, 32'hFFFFFFFF);
		reg_write(REG_BETA2, 32'h0);
		reg_write(REG_EPS, 32'h0);
		reg_write(REG_LR, 32'hFFFFFFFF);
		send_item(32'h3F800000, 32'h3F800000, 12'd10);
		send_item(32'h3F800000, 32'h0, 12'd11);
		drain();

		// random phases with fresh settings
		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 6)
				0: wc = 13'd1;
				1: wc = 13'($urandom_range(2, 16));
				2: wc = 13'd4096;
				3: wc = 13'($urandom_range(17, 300));
				4: wc = 13'h1FFF;
				default: wc = 13'($urandom_range(1, 64));
			endcase
			quiet_phase = (ph % 4 == 3);
			reg_write(REG_WCOUNT, wc);
			reg_write(REG_BETA1, rand_beta());
			reg_write(REG_BETA2, rand_beta());
			reg_write(REG_EPS, ($urandom_range(0, 9) == 0) ? $urandom
				: {9'($urandom_range(100, 120)), 23'($urandom)});
			reg_write(REG_LR, ($urandom_range(0, 9) == 0) ? $urandom
				: {9'($urandom_range(110, 124)), 23'($urandom)});
			lim = (wc > MAX_WEIGHTS) ? MAX_WEIGHTS : wc;
			n = 77;
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 9) == 0)
					idx = 12'($urandom);
				else
					idx = 12'($urandom_range(0, lim - 1));
				send_item(rand_float(), rand_float(), idx);
			end
			drain();
		end

		quiet_phase = 1'b0;
		repeat (400) @(posedge clk);
		$display("items %0d, flagged indexes %0d, optimizer steps ended %0d",
			adam_sb.items_seen, adam_sb.bad_indexes, adam_sb.steps_ended);
		$display("mismatches %0d", adam_sb.mismatches);
		if (adam_sb.mismatches == 0 && adam_sb.pending_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
